// ===== rtl/core/bf16_tile_row_argmax_top_macros.svh =====
// ----------------------------------------------------------------------------
// bf16 tile row argmax assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef BF16_TILE_ROW_ARGMAX_TOP_MACROS_SVH
`define BF16_TILE_ROW_ARGMAX_TOP_MACROS_SVH

// same-cycle implication
`define BTRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/btra_pkg.sv =====
// ----------------------------------------------------------------------------
// bf16 tile row argmax package
// Shared types, widths, register indexes and the bf16 order key.
// ----------------------------------------------------------------------------
package btra_pkg;

    localparam int TILE_ROWS = 32;
    localparam int ROW_W     = 5;
    localparam int KEY_W     = 16;
    localparam int COL_W     = 17;
    localparam int TILE_W    = 12;
    localparam int NROWS_W   = 6;

    localparam logic REG_FIRST_TILE  = 1'b0;
    localparam logic REG_ROWS_IN_USE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [KEY_W-1:0] key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // negative: invert all bits, otherwise flip the sign bit
    function automatic logic [KEY_W-1:0] order_key(input logic [15:0] h);
        logic [KEY_W-1:0] k;
        if (h[15]) begin
            k = ~h;
        end else begin
            k = h ^ 16'h8000;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/bf16_tile_row_argmax_top.sv =====
// ----------------------------------------------------------------------------
// bf16 tile row argmax
// Per-row running maximum of bf16 tile words, reported as key/column records.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tdata: word, tile, offset; tuser: mode
//  m_      | out | m_tvalid/m_tready | tdata: row, key, column; tlast: last
//  cfg_    | in  | cfg_wr_en         | cfg_wr_index, cfg_wr_data
//
// Data beats: one per cycle while idle; read row entry, then compare and write
// back in the next cycle, with a one-entry bypass for back-to-back beats of the same row.
// Finish beat: one RAM read and one record per cycle at best; input is held
// off after the finish beat until the last row's record is loaded, which m_ stalls delay.
// Reset: synchronous, clears control and per-row valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`include "bf16_tile_row_argmax_top_macros.svh"

module bf16_tile_row_argmax_top #(
    parameter int MAX_TILES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [11:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pair_word[31:0], tile_number[43:32], word_offset[52:44]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // row[4:0], best_key[20:5], best_column[37:21]
    output logic        m_tlast
);

    localparam int RW = btra_pkg::ROW_W;
    localparam int NW = btra_pkg::NROWS_W;

    // configuration
    logic [btra_pkg::TILE_W-1:0] first_tile_reg;
    logic [NW-1:0]               rows_in_use_reg;
    logic [NW-1:0]               nrows;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_tile_reg  <= '0;
            rows_in_use_reg <= NW'(btra_pkg::TILE_ROWS);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                btra_pkg::REG_FIRST_TILE:  first_tile_reg  <= cfg_wr_data;
                btra_pkg::REG_ROWS_IN_USE: rows_in_use_reg <= cfg_wr_data[NW-1:0];
                default: ;
            endcase
        end
    end

    assign nrows = (rows_in_use_reg > NW'(btra_pkg::TILE_ROWS)) ?
                   NW'(btra_pkg::TILE_ROWS) : rows_in_use_reg;

    // input decode
    logic [31:0]                 s_word;
    logic [btra_pkg::TILE_W-1:0] s_tile;
    logic [8:0]                  s_woff;
    logic                        s_accept;
    logic                        data_beat;
    logic                        fin_beat;
    logic                        tile_ok;
    logic [RW-1:0]               s0_row;
    logic [4:0]                  s0_col5;
    logic [btra_pkg::COL_W-1:0]  s0_base;
    logic [btra_pkg::KEY_W-1:0]  key_even;
    logic [btra_pkg::KEY_W-1:0]  key_odd;
    logic                        s0_go;

    assign s_word  = s_tdata[31:0];
    assign s_tile  = s_tdata[43:32];
    assign s_woff  = s_tdata[52:44];

    assign s_accept  = s_tvalid && s_tready;
    assign data_beat = s_accept && !s_tuser;
    assign fin_beat  = s_accept && s_tuser;
    assign tile_ok   = {20'd0, s_tile} < 32'(MAX_TILES);

    assign s0_row   = {s_woff[8], s_woff[6:3]};
    assign s0_col5  = {s_woff[7], s_woff[2:0], 1'b0};
    assign s0_base  = {s_tile, s0_col5};
    assign key_even = btra_pkg::order_key(s_word[15:0]);
    assign key_odd  = btra_pkg::order_key(s_word[31:16]);
    assign s0_go    = data_beat && tile_ok && ({1'b0, s0_row} < nrows);

    // stage 1: candidate of the pair, even column wins a tie
    logic                       s1_valid_reg;
    logic [RW-1:0]              s1_row_reg;
    btra_pkg::entry_t           s1_cand_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s0_go;
        end
        if (s0_go) begin
            s1_row_reg <= s0_row;
            if (key_odd > key_even) begin
                s1_cand_reg <= '{col: s0_base | btra_pkg::COL_W'(1), key: key_odd};
            end else begin
                s1_cand_reg <= '{col: s0_base, key: key_even};
            end
        end
    end

    // row memory
    logic                         ram_we;
    logic                         ram_re;
    logic [RW-1:0]                ram_raddr;
    logic [btra_pkg::ENTRY_W-1:0] ram_rdata;
    btra_pkg::entry_t             ram_entry;

    // emit sequencer
    btra_pkg::state_t state_reg, state_next;
    logic [NW-1:0]    rd_idx_reg, rd_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [RW-1:0]    rd_row_reg, rd_row_next;
    logic             issue;
    logic             load;
    logic             load_last;
    logic             clear_all;

    assign ram_re    = issue || s0_go;
    assign ram_raddr = issue ? rd_idx_reg[RW-1:0] : s0_row;
    assign ram_entry = btra_pkg::entry_t'(ram_rdata);

    // stage 1 compare with bypass of the previous write
    logic [btra_pkg::TILE_ROWS-1:0] upd_reg;
    logic                           any_seen_reg;
    logic                           fwd_valid_reg;
    logic [RW-1:0]                  fwd_row_reg;
    btra_pkg::entry_t               fwd_entry_reg;
    btra_pkg::entry_t               old_entry;
    logic                           old_upd;
    logic                           take;

    assign old_upd   = upd_reg[s1_row_reg];
    assign old_entry = (fwd_valid_reg && (fwd_row_reg == s1_row_reg)) ?
                       fwd_entry_reg : ram_entry;

    always_comb begin
        if (!old_upd) begin
            take = s1_cand_reg.key != '0;
        end else begin
            take = (s1_cand_reg.key > old_entry.key) ||
                   ((s1_cand_reg.key == old_entry.key) &&
                    (s1_cand_reg.col < old_entry.col));
        end
    end

    assign ram_we = s1_valid_reg && take;

    btra_ram #(
        .WIDTH (btra_pkg::ENTRY_W),
        .DEPTH (btra_pkg::TILE_ROWS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_row_reg),
        .wdata (s1_cand_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= ram_we;
        end
        if (ram_we) begin
            fwd_row_reg   <= s1_row_reg;
            fwd_entry_reg <= s1_cand_reg;
        end
    end

    assign clear_all = load_last || (fin_beat && (nrows == '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_reg      <= '0;
            any_seen_reg <= 1'b0;
        end else if (clear_all) begin
            upd_reg      <= '0;
            any_seen_reg <= 1'b0;
        end else begin
            if (ram_we) begin
                upd_reg[s1_row_reg] <= 1'b1;
            end
            if (data_beat && tile_ok) begin
                any_seen_reg <= 1'b1;
            end
        end
    end

    // output register
    logic                       m_valid_reg;
    logic [RW-1:0]              m_row_reg;
    logic [btra_pkg::KEY_W-1:0] m_key_reg;
    logic [btra_pkg::COL_W-1:0] m_col_reg;
    logic                       m_last_reg;
    logic                       rec_last;

    assign load      = rd_pend_reg && (!m_valid_reg || m_tready);
    assign rec_last  = ({1'b0, rd_row_reg} + NW'(1)) == nrows;
    assign load_last = load && rec_last;

    always_comb begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        rd_pend_next = rd_pend_reg;
        rd_row_next  = rd_row_reg;
        issue        = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            btra_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (fin_beat && (nrows != '0)) begin
                    state_next  = btra_pkg::ST_EMIT;
                    rd_idx_next = '0;
                end
            end
            btra_pkg::ST_EMIT: begin
                issue = (rd_idx_reg < nrows) && (!rd_pend_reg || load);
                if (issue) begin
                    rd_pend_next = 1'b1;
                    rd_row_next  = rd_idx_reg[RW-1:0];
                    rd_idx_next  = rd_idx_reg + NW'(1);
                end else if (load) begin
                    rd_pend_next = 1'b0;
                end
                if (load_last) begin
                    state_next = btra_pkg::ST_IDLE;
                end
            end
            default: state_next = btra_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= btra_pkg::ST_IDLE;
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            rd_pend_reg <= rd_pend_next;
        end
        rd_row_reg <= rd_row_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (load) begin
            m_row_reg  <= rd_row_reg;
            m_last_reg <= rec_last;
            if (upd_reg[rd_row_reg]) begin
                m_key_reg <= ram_entry.key;
                m_col_reg <= ram_entry.col;
            end else begin
                m_key_reg <= '0;
                m_col_reg <= any_seen_reg ? {first_tile_reg, 5'd0} : '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_col_reg, m_key_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

    `BTRA_ASSERT_NOW(a_pend_only_emit, rd_pend_reg, state_reg == btra_pkg::ST_EMIT, "read pending outside emit")
    `BTRA_ASSERT_NOW(a_no_data_in_emit, s1_valid_reg, !rd_pend_reg, "data update overlaps emit read")
    `BTRA_ASSERT_NOW(a_idx_bound, state_reg == btra_pkg::ST_EMIT, rd_idx_reg <= nrows, "emit index past rows in use")
    `BTRA_ASSERT_NOW(a_mid_record_emit, m_valid_reg && !m_last_reg, state_reg == btra_pkg::ST_EMIT, "non-final record outside emit")
    `BTRA_ASSERT_NEXT(a_clear_after_last, load_last, upd_reg == '0, "row state not cleared after finish")

endmodule

// ===== rtl/core/btra_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module btra_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
